// ===== rtl/pts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer scheduler package
// Operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pts_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_MODIFY  = 3'd2,
        OP_SYNC    = 3'd3,
        OP_SERVICE = 3'd4,
        OP_LOOKUP  = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_DONE        = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_NOTHING_DUE = 3'd2,
        ST_RESCHEDULED = 3'd3,
        ST_RETIRED     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_CALC,
        S_MUL,
        S_WRITE
    } state_t;

    localparam int unsigned COUNT_BITS = 32;
    localparam int unsigned SLACK_BITS = 9;

endpackage : pts_pkg
`default_nettype wire

// ===== rtl/pts_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot memory
// Synchronous memory holding due time, stop time, period and fire count of
// every slot, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pts_mem #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned TBITS = 48,
    parameter int unsigned CBITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  wire logic [3*TBITS+CBITS-1:0] wr_data,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic      [3*TBITS+CBITS-1:0] rd_data
);

    logic [3*TBITS+CBITS-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : pts_mem
`default_nettype wire

// ===== rtl/periodic_timer_scheduler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer scheduler core
// Table of timer slots with add, remove, modify, sync, service and lookup.
// ----------------------------------------------------------------------------
// Timing: one command at a time; busy is high from the accepting edge until
// the result strobe. Sync passes through an extra state (S_MUL) for the slack
// product, and service first finds the earliest due slot by reading the slot
// memory one entry a cycle through its single read port. The result is shown
// for one cycle on done and cannot be held off, so the receiver must take it then.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler_core #(
    parameter int unsigned TIMER_SLOTS = 16,
    parameter int unsigned TIME_BITS   = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [2:0]            opcode,
    input  wire logic [3:0]            timer_id,
    input  wire logic [TIME_BITS-1:0]  now_time,
    input  wire logic [TIME_BITS-1:0]  run_time,
    input  wire logic [TIME_BITS-1:0]  stop_time,
    input  wire logic [TIME_BITS-1:0]  repeat_time,
    input  wire logic [8:0]            slack_fraction,
    output logic                       done,
    output logic [2:0]                 status,
    output logic [3:0]                 result_id,
    output logic [31:0]                fire_count,
    output logic [TIME_BITS-1:0]       next_due,
    output logic                       recalibrate
);

    localparam int unsigned AW = $clog2(TIMER_SLOTS);
    localparam int unsigned CB = pts_pkg::COUNT_BITS;
    localparam int unsigned DW = 3*TIME_BITS + CB;
    localparam int unsigned PW = TIME_BITS + pts_pkg::SLACK_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam logic [CB-1:0] CMAX = '1;

    pts_pkg::state_t state_reg, state_next;
    logic [TIMER_SLOTS-1:0] valid_reg;

    logic [2:0]           op_reg;
    logic [3:0]           id_reg;
    logic [TIME_BITS-1:0] now_reg, run_reg, stop_reg, rep_reg;
    logic [8:0]           slack_reg;
    logic                 in_table_reg;

    logic [AW:0]          scan_reg;      // address issued
    logic                 rv_reg;        // read data valid during scan
    logic [AW-1:0]        rv_addr_reg;
    logic                 found_reg;
    logic [AW-1:0]        best_reg;
    logic [TIME_BITS-1:0] best_due_reg;

    logic [DW-1:0]        rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;

    logic [TIME_BITS-1:0] m_due, m_stop, m_per;
    logic [CB-1:0]        m_cnt;
    logic [TIME_BITS-1:0] e_due_reg, e_stop_reg, e_per_reg;
    logic [CB-1:0]        e_cnt_reg;
    logic [PW-1:0]        prod_reg;
    logic [AW-1:0]        slot_sel;

    assign {m_due, m_stop, m_per, m_cnt} = rd_data;
    assign slot_sel = AW'(id_reg);

    pts_mem #(.SLOTS(TIMER_SLOTS), .TBITS(TIME_BITS), .CBITS(CB)) u_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Service arithmetic on the winning entry.
    logic [TIME_BITS:0]   sum_sat;
    logic [TIME_BITS-1:0] svc_due;
    logic [CB-1:0]        svc_cnt;
    logic                 svc_keep;
    always_comb
    begin
        sum_sat = {1'b0, e_due_reg} + {1'b0, e_per_reg};
        svc_due = sum_sat[TIME_BITS] ? TMAX : sum_sat[TIME_BITS-1:0];
        svc_cnt = (e_cnt_reg == CMAX) ? e_cnt_reg : e_cnt_reg + 1'b1;
        svc_keep = (e_per_reg != '0)
                   && ((e_stop_reg == '0) || (svc_due < e_stop_reg));
    end

    // Sync test: due before now, or due - now < period * slack / 256, with the product held
    // exactly as TIME_BITS+9 bits (compare diff*256 against it).
    logic [TIME_BITS-1:0] diff;
    logic                 sync_hit;
    always_comb
    begin
        diff = e_due_reg - now_reg;
        sync_hit = (e_due_reg < now_reg)
                   || ({1'b0, diff, 8'd0} < prod_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        rd_addr = slot_sel;
        wr_en = 1'b0;
        wr_addr = slot_sel;
        wr_data = {e_due_reg, e_stop_reg, e_per_reg, e_cnt_reg};
        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                rd_addr = AW'(timer_id);
                if (start)
                begin
                    state_next = (opcode == pts_pkg::OP_SERVICE)
                                 ? pts_pkg::S_SCAN : pts_pkg::S_READ;
                end
            end
            pts_pkg::S_SCAN:
            begin
                rd_addr = scan_reg[AW-1:0];
                if (!rv_reg && scan_reg == AW'(0) + (AW+1)'(TIMER_SLOTS))
                begin
                    state_next = pts_pkg::S_READ;
                end
                if (scan_reg == (AW+1)'(TIMER_SLOTS))
                begin
                    rd_addr = best_reg;
                end
            end
            pts_pkg::S_READ:
            begin
                // Keep the winning entry on the read port for the capture.
                if (op_reg == pts_pkg::OP_SERVICE)
                begin
                    rd_addr = best_reg;
                end
                state_next = pts_pkg::S_CALC;
            end
            pts_pkg::S_CALC:
            begin
                state_next = (op_reg == pts_pkg::OP_SYNC)
                             ? pts_pkg::S_MUL : pts_pkg::S_WRITE;
            end
            pts_pkg::S_MUL:
            begin
                state_next = pts_pkg::S_WRITE;
            end
            pts_pkg::S_WRITE:
            begin
                state_next = pts_pkg::S_IDLE;
                priority if (op_reg == pts_pkg::OP_SERVICE)
                begin
                    wr_addr = best_reg;
                    wr_en = found_reg && (best_due_reg <= now_reg);
                    wr_data = {svc_due, e_stop_reg, e_per_reg, svc_cnt};
                end
                else if (in_table_reg)
                begin
                    unique case (op_reg)
                        pts_pkg::OP_ADD:
                        begin
                            wr_en = 1'b1;
                            wr_data = {run_reg, stop_reg, rep_reg, CB'(0)};
                        end
                        pts_pkg::OP_MODIFY:
                        begin
                            wr_en = valid_reg[slot_sel];
                            wr_data = {(run_reg != '0) ? run_reg : e_due_reg,
                                       (stop_reg != '0) ? stop_reg : e_stop_reg,
                                       (rep_reg != '0) ? rep_reg : e_per_reg,
                                       e_cnt_reg};
                        end
                        pts_pkg::OP_SYNC:
                        begin
                            wr_en = valid_reg[slot_sel] && sync_hit;
                            wr_data = {now_reg + e_per_reg, e_stop_reg,
                                       e_per_reg, e_cnt_reg};
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::S_IDLE;
            valid_reg <= '0;
            done <= 1'b0;
            rv_reg <= 1'b0;
            scan_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= 1'b0;
            unique case (state_reg)
                pts_pkg::S_IDLE:
                begin
                    scan_reg <= '0;
                    rv_reg <= 1'b0;
                    found_reg <= 1'b0;
                end
                pts_pkg::S_SCAN:
                begin
                    if (scan_reg != (AW+1)'(TIMER_SLOTS))
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        rv_reg <= 1'b1;
                        rv_addr_reg <= scan_reg[AW-1:0];
                    end
                    else
                    begin
                        rv_reg <= 1'b0;
                    end
                    if (rv_reg && valid_reg[rv_addr_reg]
                        && (!found_reg || m_due < best_due_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                pts_pkg::S_WRITE:
                begin
                    done <= 1'b1;
                    if (op_reg == pts_pkg::OP_SERVICE)
                    begin
                        if (found_reg && best_due_reg <= now_reg && !svc_keep)
                        begin
                            valid_reg[best_reg] <= 1'b0;
                        end
                    end
                    else if (in_table_reg && op_reg == pts_pkg::OP_ADD)
                    begin
                        valid_reg[slot_sel] <= 1'b1;
                    end
                    else if (in_table_reg && op_reg == pts_pkg::OP_REMOVE)
                    begin
                        valid_reg[slot_sel] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == pts_pkg::S_IDLE && start)
        begin
            op_reg <= opcode;
            id_reg <= timer_id;
            now_reg <= now_time;
            run_reg <= run_time;
            stop_reg <= stop_time;
            rep_reg <= repeat_time;
            slack_reg <= slack_fraction;
            in_table_reg <= ({28'd0, timer_id} < 32'(TIMER_SLOTS));
        end
        if (state_reg == pts_pkg::S_SCAN && rv_reg && valid_reg[rv_addr_reg]
            && (!found_reg || m_due < best_due_reg))
        begin
            best_reg <= rv_addr_reg;
            best_due_reg <= m_due;
        end
        if (state_reg == pts_pkg::S_CALC)
        begin
            e_due_reg <= m_due;
            e_stop_reg <= m_stop;
            e_per_reg <= m_per;
            e_cnt_reg <= m_cnt;
        end
        if (state_reg == pts_pkg::S_MUL)
        begin
            prod_reg <= PW'(e_per_reg) * PW'(slack_reg);
        end
        if (state_reg == pts_pkg::S_WRITE)
        begin
            status <= pts_pkg::ST_DONE;
            result_id <= id_reg;
            fire_count <= '0;
            next_due <= '0;
            recalibrate <= 1'b0;
            if (op_reg == pts_pkg::OP_SERVICE)
            begin
                result_id <= '0;
                if (!found_reg || best_due_reg > now_reg)
                begin
                    status <= pts_pkg::ST_NOTHING_DUE;
                end
                else
                begin
                    status <= svc_keep ? pts_pkg::ST_RESCHEDULED
                                       : pts_pkg::ST_RETIRED;
                    recalibrate <= svc_keep;
                    result_id <= 4'(best_reg);
                    fire_count <= svc_cnt;
                    next_due <= (e_per_reg != '0) ? svc_due : e_due_reg;
                end
            end
            else if (op_reg <= pts_pkg::OP_LOOKUP)
            begin
                if (!in_table_reg
                    || (op_reg != pts_pkg::OP_ADD && !valid_reg[slot_sel]))
                begin
                    status <= pts_pkg::ST_NOT_FOUND;
                end
                else if (op_reg == pts_pkg::OP_LOOKUP)
                begin
                    fire_count <= e_cnt_reg;
                    next_due <= e_due_reg;
                end
                else if (op_reg != pts_pkg::OP_ADD)
                begin
                    recalibrate <= 1'b1;
                end
            end
        end
    end

    assign busy = (state_reg != pts_pkg::S_IDLE);

endmodule : periodic_timer_scheduler_core
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Periodic timer scheduler testbench
// Drives add, remove, modify, sync, service and lookup commands into the core.
// It predicts every result with its own copy of the timer table and checks
// each result strobe, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import pts_pkg::*;

    localparam int          SLOTS        = 16;
    localparam int          TBITS        = 48;
    localparam logic [2:0]  OP_UNUSED_LO = 3'd6;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
    localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]  st;
        logic [3:0]  id;
        logic [31:0] cnt;
        logic [47:0] due;
        logic        recal;
    } timer_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [2:0]        opcode = '0;
    logic [3:0]        timer_id = '0;
    logic [TBITS-1:0]  now_time = '0;
    logic [TBITS-1:0]  run_time = '0;
    logic [TBITS-1:0]  stop_time = '0;
    logic [TBITS-1:0]  repeat_time = '0;
    logic [8:0]        slack_fraction = '0;
    logic              busy;
    logic              done;
    logic [2:0]        status;
    logic [3:0]        result_id;
    logic [31:0]       fire_count;
    logic [TBITS-1:0]  next_due;
    logic              recalibrate;

    // Shadow copy of the timer table.
    logic              tbl_valid [SLOTS];
    logic [47:0]       tbl_due   [SLOTS];
    logic [47:0]       tbl_stop  [SLOTS];
    logic [47:0]       tbl_per   [SLOTS];
    logic [31:0]       tbl_count [SLOTS];

    timer_result_t     pending_results[$];
    int                error_count = 0;
    int                idle_pct = 0;
    logic [47:0]       sim_now = 48'd1000;

    periodic_timer_scheduler_core #(.TIMER_SLOTS(SLOTS), .TIME_BITS(TBITS)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .timer_id(timer_id), .now_time(now_time),
        .run_time(run_time), .stop_time(stop_time), .repeat_time(repeat_time),
        .slack_fraction(slack_fraction), .done(done), .status(status),
        .result_id(result_id), .fire_count(fire_count), .next_due(next_due),
        .recalibrate(recalibrate)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The threshold is period * slack / 256; compare diff * 256 exactly.
    function automatic logic sync_due(logic [47:0] due, logic [47:0] now,
                                      logic [47:0] per, logic [8:0] slack);
        logic [65:0] lhs;
        logic [65:0] rhs;
        if (due < now)
            return 1'b1;
        lhs = {10'd0, due - now, 8'd0};
        rhs = 66'(per) * 66'(slack);
        return lhs < rhs;
    endfunction

    function automatic timer_result_t apply_command(logic [2:0] op, logic [3:0] id,
                                                    logic [47:0] now, logic [47:0] run,
                                                    logic [47:0] stop, logic [47:0] per,
                                                    logic [8:0] slack);
        timer_result_t r;
        int            best;
        logic          found;
        logic [48:0]   sum;
        logic [47:0]   nd;
        r = '{st: ST_DONE, id: id, cnt: '0, due: '0, recal: 1'b0};
        if (op == OP_SERVICE) begin
            r.id = '0;
            found = 1'b0;
            best = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_valid[i] && (!found || tbl_due[i] < tbl_due[best])) begin
                    best = i;
                    found = 1'b1;
                end
            end
            if (!found || tbl_due[best] > now) begin
                r.st = ST_NOTHING_DUE;
            end else begin
                nd = tbl_due[best];
                if (tbl_count[best] != 32'hFFFF_FFFF)
                    tbl_count[best]++;
                if (tbl_per[best] != 0) begin
                    sum = {1'b0, nd} + {1'b0, tbl_per[best]};
                    nd = sum[48] ? TIME_MAX : sum[47:0];
                    tbl_due[best] = nd;
                    if (tbl_stop[best] == 0 || nd < tbl_stop[best]) begin
                        r.st = ST_RESCHEDULED;
                        r.recal = 1'b1;
                    end else begin
                        r.st = ST_RETIRED;
                        tbl_valid[best] = 1'b0;
                    end
                end else begin
                    r.st = ST_RETIRED;
                    tbl_valid[best] = 1'b0;
                end
                r.id = 4'(best);
                r.cnt = tbl_count[best];
                r.due = nd;
            end
        end else if (op == OP_UNUSED_LO || op == OP_UNUSED_HI) begin
            r.st = ST_DONE;
        end else if (op != OP_ADD && !tbl_valid[id]) begin
            r.st = ST_NOT_FOUND;
        end else begin
            case (op)
                OP_ADD:
                begin
                    tbl_valid[id] = 1'b1;
                    tbl_due[id] = run;
                    tbl_stop[id] = stop;
                    tbl_per[id] = per;
                    tbl_count[id] = '0;
                end
                OP_REMOVE:
                begin
                    tbl_valid[id] = 1'b0;
                    r.recal = 1'b1;
                end
                OP_MODIFY:
                begin
                    if (run != 0) tbl_due[id] = run;
                    if (stop != 0) tbl_stop[id] = stop;
                    if (per != 0) tbl_per[id] = per;
                    r.recal = 1'b1;
                end
                OP_SYNC:
                begin
                    if (sync_due(tbl_due[id], now, tbl_per[id], slack))
                        tbl_due[id] = now + tbl_per[id];
                    r.recal = 1'b1;
                end
                default:
                begin
                    r.cnt = tbl_count[id];
                    r.due = tbl_due[id];
                end
            endcase
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the accepting edge or after idling.
    task automatic send_command(logic [2:0] op, logic [3:0] id, logic [47:0] now,
                                logic [47:0] run, logic [47:0] stop, logic [47:0] per,
                                logic [8:0] slack);
        start <= 1'b1;
        opcode <= op;
        timer_id <= id;
        now_time <= now;
        run_time <= run;
        stop_time <= stop;
        repeat_time <= per;
        slack_fraction <= slack;
        do @(posedge clk); while (busy);
        pending_results.push_back(apply_command(op, id, now, run, stop, per, slack));
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        timer_result_t exp_r;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st) begin
                    $error("status: expected %0d, actual %0d", exp_r.st, status);
                    error_count++;
                end
                if (result_id !== exp_r.id) begin
                    $error("result_id: expected %0d, actual %0d", exp_r.id, result_id);
                    error_count++;
                end
                if (fire_count !== exp_r.cnt) begin
                    $error("fire_count: expected %0d, actual %0d", exp_r.cnt, fire_count);
                    error_count++;
                end
                if (next_due !== exp_r.due) begin
                    $error("next_due: expected %0h, actual %0h", exp_r.due, next_due);
                    error_count++;
                end
                if (recalibrate !== exp_r.recal) begin
                    $error("recalibrate: expected %0b, actual %0b", exp_r.recal,
                           recalibrate);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [47:0] wide_random();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_command(OP_SERVICE, 4'd0, 48'd0, 0, 0, 0, 9'd0);
        send_command(OP_LOOKUP, 4'd3, 48'd0, 0, 0, 0, 9'd0);
        send_command(OP_REMOVE, 4'd15, 48'd0, 0, 0, 0, 9'd0);
        send_command(OP_MODIFY, 4'd7, 48'd0, 48'd5, 0, 0, 9'd0);
        send_command(OP_SYNC, 4'd9, 48'd0, 0, 0, 0, 9'd256);
        send_command(OP_ADD, 4'd15, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 9'h1FF);
        send_command(OP_LOOKUP, 4'd15, 48'd0, 0, 0, 0, 9'd0);
        send_command(OP_ADD, 4'd0, 48'd0, 48'd100, 48'd0, 48'd50, 9'd0);
        send_command(OP_ADD, 4'd1, 48'd0, 48'd100, 48'd230, 48'd70, 9'd0);
        send_command(OP_ADD, 4'd2, 48'd0, 48'd120, 48'd0, 48'd0, 9'd0);
        // Slots 0 and 1 tie at 100; the lower slot fires first.
        send_command(OP_SERVICE, 4'd0, 48'd99, 0, 0, 0, 9'd0);
        send_command(OP_SERVICE, 4'd0, 48'd100, 0, 0, 0, 9'd0);
        send_command(OP_SERVICE, 4'd0, 48'd200, 0, 0, 0, 9'd0);
        send_command(OP_SERVICE, 4'd0, 48'd200, 0, 0, 0, 9'd0);
        send_command(OP_SERVICE, 4'd0, 48'd200, 0, 0, 0, 9'd0);
        send_command(OP_SERVICE, 4'd0, 48'd300, 0, 0, 0, 9'd0);
        send_command(OP_MODIFY, 4'd0, 48'd0, 48'd0, 48'd0, 48'd0, 9'd0);
        send_command(OP_MODIFY, 4'd0, 48'd0, 48'd500, 48'd900, 48'd300, 9'd0);
        send_command(OP_SYNC, 4'd0, 48'd400, 0, 0, 0, 9'd0);
        send_command(OP_SYNC, 4'd0, 48'd400, 0, 0, 0, 9'd256);
        send_command(OP_SYNC, 4'd0, 48'd900, 0, 0, 0, 9'h1FF);
        send_command(OP_UNUSED_LO, 4'd5, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 9'h1FF);
        send_command(OP_UNUSED_HI, 4'd10, 48'd0, 0, 0, 0, 9'd0);
        // Saturating reschedule of the slot at the top of time, then retire.
        send_command(OP_REMOVE, 4'd0, 48'd0, 0, 0, 0, 9'd0);
        send_command(OP_SERVICE, 4'd0, TIME_MAX, 0, 0, 0, 9'd0);
        wait_all_results();
    endtask

    task automatic random_command();
        logic [2:0]  op;
        logic [47:0] now;
        logic [47:0] run;
        logic [47:0] stop;
        logic [47:0] per;
        logic [8:0]  slack;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 20) op = OP_ADD;
        else if (pick < 27) op = OP_REMOVE;
        else if (pick < 37) op = OP_MODIFY;
        else if (pick < 50) op = OP_SYNC;
        else if (pick < 85) op = OP_SERVICE;
        else if (pick < 95) op = OP_LOOKUP;
        else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        sim_now = sim_now + 48'($urandom_range(0, 40));
        now = ($urandom_range(99) < 3) ? wide_random() : sim_now;
        pick = $urandom_range(99);
        run = (pick < 15) ? 48'd0 : (pick < 20) ? wide_random()
            : sim_now + 48'($urandom_range(0, 200));
        pick = $urandom_range(99);
        stop = (pick < 50) ? 48'd0 : (pick < 55) ? wide_random()
            : sim_now + 48'($urandom_range(0, 1000));
        pick = $urandom_range(99);
        per = (pick < 20) ? 48'd0 : (pick < 25) ? wide_random()
            : 48'($urandom_range(1, 120));
        slack = 9'($urandom_range(0, 511));
        send_command(op, 4'($urandom_range(0, 15)), now, run, stop, per, slack);
    endtask

    task automatic test_random(int pct, int count);
        idle_pct = pct;
        repeat (count) random_command();
        idle_pct = 0;
        wait_all_results();
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_due[i] = '0;
            tbl_stop[i] = '0;
            tbl_per[i] = '0;
            tbl_count[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 300);
        test_random(82, 280);
        test_random(21, 280);
        test_random(0, 270);
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== periodic_timer_scheduler_core.f =====
rtl/pts_pkg.sv
rtl/pts_mem.sv
rtl/periodic_timer_scheduler_core.sv
dv/testbench.sv
